// ===== hdl/gsig_pkg.sv =====
// Shared types and constants for the grid skirt index generator.
// Used by gsig_datapath and grid_skirt_index_generator; no dependencies.
package gsig_pkg;

  // Default largest grid side, in quads.
  localparam int GRID_MAX_DEF = 256;

  // Configuration port and payload widths.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE  = 1'b0,
    CFG_INDICES_EN = 1'b1
  } gsig_cfg_reg_e;

  typedef enum logic [2:0] {
    PH_GRID  = 3'd0,
    PH_WEST  = 3'd1,
    PH_SOUTH = 3'd2,
    PH_EAST  = 3'd3,
    PH_NORTH = 3'd4,
    PH_DONE  = 3'd5
  } gsig_phase_e;

  // Per-pair control that travels with the operands into the datapath.
  typedef struct packed {
    gsig_phase_e phase;
    logic        last;
  } gsig_ctrl_t;

endpackage

// ===== hdl/gsig_datapath.sv =====
// Two-stage index datapath: registered products, then index assembly
// into the output register. Depends on gsig_pkg.
module gsig_datapath #(
  parameter int GRID_MAX = gsig_pkg::GRID_MAX_DEF,
  parameter int CW       = 8,
  parameter int NW       = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        op_valid_i,
  output logic                        op_stall_o,
  input  gsig_pkg::gsig_ctrl_t        op_ctrl_i,
  input  logic [CW-1:0]               op_col_i,
  input  logic [CW-1:0]               op_row_i,
  input  logic [NW-1:0]               op_n_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gsig_pkg::IDX_W-1:0]  index_a_o,
  output logic [gsig_pkg::IDX_W-1:0]  index_b_o,
  output logic [gsig_pkg::IDX_W-1:0]  index_c_o,
  output logic [gsig_pkg::IDX_W-1:0]  index_d_o,
  output logic [gsig_pkg::IDX_W-1:0]  index_e_o,
  output logic [gsig_pkg::IDX_W-1:0]  index_f_o,
  output logic                        on_skirt_o,
  output logic                        last_pair_o
);
  import gsig_pkg::*;

  localparam int PW = 2 * NW + 1;

  // Multiplier operands.
  logic [NW-1:0]   mul_r;
  logic [NW:0]     mul_s;
  logic [PW-1:0]   m1_d, m2_d;

  // Product stage.
  logic            s1_vld_q;
  gsig_ctrl_t      s1_ctrl_q;
  logic [CW-1:0]   s1_col_q;
  logic [NW-1:0]   s1_n_q;
  logic [PW-1:0]   s1_m1_q, s1_m2_q;

  // Assembly.
  logic [PW-1:0]   colx, nx;
  logic [PW-1:0]   ga, gb, gc, gd;
  logic [PW-1:0]   ta, tb, sa, sb;
  logic [PW-1:0]   v0, v1, v2, v3, v4, v5;
  logic            skirt;

  logic            out_vld_q;
  logic            out_adv, s1_take;

  always_comb begin
    mul_s = '0;
    case (op_ctrl_i.phase)
      PH_GRID:  mul_r = NW'(op_row_i);
      PH_WEST:  mul_r = NW'(op_col_i);
      PH_SOUTH: mul_r = op_n_i - 1'b1;
      PH_EAST:  mul_r = op_n_i - 1'b1 - NW'(op_col_i);
      default:  mul_r = '0;
    endcase
    case (op_ctrl_i.phase)
      PH_WEST:  mul_s = (NW+1)'(op_n_i);
      PH_SOUTH: mul_s = (NW+1)'(op_n_i) + (NW+1)'(1);
      PH_EAST:  mul_s = (NW+1)'(op_n_i) + (NW+1)'(2);
      PH_NORTH: mul_s = (NW+1)'(op_n_i) + (NW+1)'(3);
      default:  mul_s = '0;
    endcase
  end

  // Row base (or edge base) and skirt base: n*n + e*n = n*(n+e).
  assign m1_d = PW'(mul_r) * PW'(op_n_i);
  assign m2_d = PW'(mul_s) * PW'(op_n_i);

  // The output register frees when it is empty or being taken.
  assign out_adv    = ~out_vld_q | ~out_stall_i;
  assign s1_take    = ~s1_vld_q | out_adv;
  assign op_stall_o = ~s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_take) begin
      s1_vld_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && op_valid_i) begin
      s1_ctrl_q <= op_ctrl_i;
      s1_col_q  <= op_col_i;
      s1_n_q    <= op_n_i;
      s1_m1_q   <= m1_d;
      s1_m2_q   <= m2_d;
    end
  end

  assign colx = PW'(s1_col_q);
  assign nx   = PW'(s1_n_q);
  assign ga   = s1_m1_q + colx;
  assign gb   = ga + 1'b1;
  assign gc   = ga + nx;
  assign gd   = gc + 1'b1;
  assign sa   = s1_m2_q + colx;
  assign sb   = sa + 1'b1;

  always_comb begin
    case (s1_ctrl_q.phase)
      PH_WEST: begin
        ta = s1_m1_q;
        tb = s1_m1_q + nx;
      end
      PH_SOUTH: begin
        ta = s1_m1_q + colx;
        tb = s1_m1_q + colx + 1'b1;
      end
      PH_EAST: begin
        // Walking north, the next edge vertex sits one row up.
        ta = s1_m1_q + nx - 1'b1;
        tb = s1_m1_q - 1'b1;
      end
      default: begin
        ta = nx - 1'b1 - colx;
        tb = nx - 2'd2 - colx;
      end
    endcase
    skirt = (s1_ctrl_q.phase != PH_GRID);
    if (skirt) begin
      v0 = ta; v1 = tb; v2 = sa;
      v3 = sa; v4 = tb; v5 = sb;
    end else begin
      v0 = ga; v1 = gc; v2 = gb;
      v3 = gb; v4 = gc; v5 = gd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_vld_q) begin
      index_a_o   <= IDX_W'(v0);
      index_b_o   <= IDX_W'(v1);
      index_c_o   <= IDX_W'(v2);
      index_d_o   <= IDX_W'(v3);
      index_e_o   <= IDX_W'(v4);
      index_f_o   <= IDX_W'(v5);
      on_skirt_o  <= skirt;
      last_pair_o <= s1_ctrl_q.last;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== hdl/grid_skirt_index_generator.sv =====
// Top level of the grid skirt index generator: configuration registers and
// the quad sequencer. Depends on gsig_pkg and gsig_datapath.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------
//   in       | in        | in_valid_i / in_stall_o | restart_i
//   out      | out       | out_valid_o/out_stall_i | index_a_o..index_f_o,
//            |           |                        | on_skirt_o, last_pair_o
//   cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item per cycle is accepted while in_stall_o is low; the sequencer and the
// product register load at the accepting edge, and the pair moves on into the
// output register once it frees. The product stage holds two small multipliers.
// Reset leaves grid size 1, pairs enabled and the sequencer on the first
// grid quad. Input stalls only while both pipeline registers hold pairs and
// the output is stalled; an item yielding no pair moves state only on restart.
module grid_skirt_index_generator #(
  parameter int GRID_MAX = gsig_pkg::GRID_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gsig_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gsig_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gsig_pkg::IDX_W-1:0]      index_a_o,
  output logic [gsig_pkg::IDX_W-1:0]      index_b_o,
  output logic [gsig_pkg::IDX_W-1:0]      index_c_o,
  output logic [gsig_pkg::IDX_W-1:0]      index_d_o,
  output logic [gsig_pkg::IDX_W-1:0]      index_e_o,
  output logic [gsig_pkg::IDX_W-1:0]      index_f_o,
  output logic                            on_skirt_o,
  output logic                            last_pair_o
);
  import gsig_pkg::*;

  localparam int CW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW = $clog2(GRID_MAX + 2);
  localparam int GW = (NW > CFG_W) ? NW : CFG_W;

  logic [CFG_W-1:0] grid_size_q;
  logic             indices_en_q;

  gsig_phase_e      phase_q, phase_d, ph_r;
  logic [CW-1:0]    col_q, col_d, col_r, col_s;
  logic [CW-1:0]    row_q, row_d, row_r, row_s;

  logic [GW-1:0]    gsz, g_eff;
  logic [CW-1:0]    gm1;
  logic [NW-1:0]    n;
  logic             accept, emit, col_end, row_end;
  gsig_ctrl_t       op_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q  <= CFG_W'(1);
      indices_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (gsig_cfg_reg_e'(cfg_idx_i))
        CFG_GRID_SIZE:  grid_size_q  <= cfg_data_i;
        CFG_INDICES_EN: indices_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective grid side, clamped to 1..GRID_MAX.
  always_comb begin
    gsz = GW'(grid_size_q);
    if (gsz == '0) begin
      g_eff = GW'(1);
    end else if (gsz > GW'(GRID_MAX)) begin
      g_eff = GW'(GRID_MAX);
    end else begin
      g_eff = gsz;
    end
  end

  assign gm1 = CW'(g_eff - 1'b1);
  assign n   = NW'(gm1) + NW'(2);

  assign accept = in_valid_i & ~in_stall_o;

  always_comb begin
    ph_r    = restart_i ? PH_GRID : phase_q;
    col_r   = restart_i ? '0 : col_q;
    row_r   = restart_i ? '0 : row_q;
    emit    = indices_en_q & (ph_r == PH_GRID || ph_r == PH_WEST || ph_r == PH_SOUTH ||
                              ph_r == PH_EAST || ph_r == PH_NORTH);
    // A grid size shrunk mid-list pulls the position back inside the grid.
    col_s   = (col_r > gm1) ? gm1 : col_r;
    row_s   = (row_r > gm1) ? gm1 : row_r;
    col_end = (col_s == gm1);
    row_end = (row_s == gm1);

    phase_d = ph_r;
    col_d   = col_r;
    row_d   = row_r;
    op_ctrl.phase = ph_r;
    op_ctrl.last  = (ph_r == PH_NORTH) & col_end;

    if (emit) begin
      row_d = row_s;
      col_d = col_end ? '0 : CW'(col_s + 1'b1);
      unique case (ph_r)
        PH_GRID: begin
          if (col_end) begin
            if (row_end) begin
              row_d   = '0;
              phase_d = PH_WEST;
            end else begin
              row_d = CW'(row_s + 1'b1);
            end
          end
        end
        PH_WEST:  if (col_end) phase_d = PH_SOUTH;
        PH_SOUTH: if (col_end) phase_d = PH_EAST;
        PH_EAST:  if (col_end) phase_d = PH_NORTH;
        PH_NORTH: if (col_end) phase_d = PH_DONE;
        default:  phase_d = ph_r;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GRID;
      col_q   <= '0;
      row_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  gsig_datapath #(
    .GRID_MAX (GRID_MAX),
    .CW       (CW),
    .NW       (NW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (accept & emit),
    .op_stall_o  (in_stall_o),
    .op_ctrl_i   (op_ctrl),
    .op_col_i    (col_s),
    .op_row_i    (row_s),
    .op_n_i      (n),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .index_a_o   (index_a_o),
    .index_b_o   (index_b_o),
    .index_c_o   (index_c_o),
    .index_d_o   (index_d_o),
    .index_e_o   (index_e_o),
    .index_f_o   (index_f_o),
    .on_skirt_o  (on_skirt_o),
    .last_pair_o (last_pair_o)
  );

endmodule
